### rtl/core/csvft_pkg.sv
// Package for the CSV field tokenizer: character codes, token kinds and the
// flag and token structs shared by the decoder and the top level. No dependencies.
package csvft_pkg;

   localparam int ByteWidth = 8;
   localparam int KindWidth = 3;

   typedef logic [ByteWidth-1:0] byte_type;
   typedef logic [KindWidth-1:0] kind_type;

   localparam byte_type CH_COMMA   = 8'h2C;
   localparam byte_type CH_NEWLINE = 8'h0A;
   localparam byte_type CH_QUOTE   = 8'h22;
   localparam byte_type CH_END     = 8'h00;

   localparam kind_type KIND_BYTE  = 3'd0;
   localparam kind_type KIND_FIELD = 3'd1;
   localparam kind_type KIND_ROW   = 3'd2;
   localparam kind_type KIND_INPUT = 3'd3;
   localparam kind_type KIND_ERROR = 3'd4;

   typedef struct packed {
      logic quote_opened;
      logic quote_closed;
      logic held_quote;
   } flags_type;

   typedef struct packed {
      kind_type token_kind;
      byte_type field_byte;
   } token_type;

endpackage

### rtl/core/csvft_stream_if.sv
// Valid/ready channel interfaces for the CSV field tokenizer: one carries
// request bytes, the other tokens. Depends on csvft_pkg.
interface csvft_req_if import csvft_pkg::*; ();
   logic     valid;
   logic     ready;
   byte_type text_byte;

   modport source (output valid, output text_byte, input ready);
   modport sink   (input valid, input text_byte, output ready);
endinterface

interface csvft_rsp_if import csvft_pkg::*; ();
   logic     valid;
   logic     ready;
   kind_type token_kind;
   byte_type field_byte;

   modport source (output valid, output token_kind, output field_byte, input ready);
   modport sink   (input valid, input token_kind, input field_byte, output ready);
endinterface

### rtl/core/csvft_decode.sv
// Per-byte decoder of the CSV field tokenizer: from the quote flags and one
// byte, the next flags and at most one token. Depends on csvft_pkg.
module csvft_decode import csvft_pkg::*; (
   input  flags_type flags,
   input  byte_type  text_byte,
   output flags_type flags_next,
   output logic      emit,
   output token_type token
);

   flags_type after_held;
   logic      is_quote;
   logic      is_delim;

   assign is_quote = (text_byte == CH_QUOTE);
   assign is_delim = (text_byte == CH_COMMA) || (text_byte == CH_NEWLINE) ||
                     (text_byte == CH_END);

   // A held quote not followed by a quote acts as a lone quote:
   // opens quoting first, closes it afterwards.
   always_comb begin
      after_held = flags;
      if (flags.held_quote && !is_quote) begin
         after_held.held_quote = 1'b0;
         if (flags.quote_opened) begin
            after_held.quote_closed = 1'b1;
         end else begin
            after_held.quote_opened = 1'b1;
         end
      end
   end

   always_comb begin
      flags_next       = after_held;
      emit             = 1'b1;
      token.token_kind = KIND_BYTE;
      token.field_byte = text_byte;
      priority if (flags.held_quote && is_quote) begin
         // doubled quote: one literal quote
         flags_next.held_quote = 1'b0;
      end else if (is_quote) begin
         flags_next.held_quote = 1'b1;
         emit                  = 1'b0;
      end else if (is_delim && (after_held.quote_opened == after_held.quote_closed)) begin
         flags_next       = '0;
         token.field_byte = CH_END;
         if (text_byte == CH_COMMA) begin
            token.token_kind = KIND_FIELD;
         end else if (text_byte == CH_NEWLINE) begin
            token.token_kind = KIND_ROW;
         end else begin
            token.token_kind = KIND_INPUT;
         end
      end else if (text_byte == CH_END) begin
         flags_next       = '0;
         token.token_kind = KIND_ERROR;
         token.field_byte = CH_END;
      end else begin
         token.token_kind = KIND_BYTE;
      end
   end

endmodule

### rtl/core/csv_field_tokenizer_unit.sv
// CSV field tokenizer. Takes one text byte per request (0 ends the input) and
// gives at most one token per byte: a field byte, a field end, a row end, an
// input end, or an unterminated-quote error. Throughput is one byte per clock
// while the token output is not stalled. An accepted byte is loaded into the
// input register; its decoded token is then loaded into the result register
// once the output is not stalled. The only loop is the three quote flags.
// Bytes that give no token (a quote held for lookahead) are still taken at full
// rate. Depends on csvft_pkg, csvft_decode and the csvft channel interfaces.
module csv_field_tokenizer_unit import csvft_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   csvft_req_if.sink   req,
   csvft_rsp_if.source rsp
);

   logic      in_valid_ff, in_valid_in;
   byte_type  in_byte_ff;
   flags_type flags_ff, flags_in;
   logic      out_valid_ff, out_valid_in;
   token_type out_token_ff;

   flags_type dec_flags;
   logic      dec_emit;
   token_type dec_token;
   logic      advance;
   logic      req_fire;

   csvft_decode u_decode (
      .flags      (flags_ff),
      .text_byte  (in_byte_ff),
      .flags_next (dec_flags),
      .emit       (dec_emit),
      .token      (dec_token)
   );

   assign advance   = in_valid_ff && (!out_valid_ff || rsp.ready);
   assign req.ready = !in_valid_ff || advance;
   assign req_fire  = req.valid && req.ready;

   assign in_valid_in  = req_fire ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
   assign flags_in     = advance ? dec_flags : flags_ff;
   assign out_valid_in = advance ? dec_emit : (out_valid_ff && !rsp.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         flags_ff     <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         flags_ff     <= flags_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         in_byte_ff <= req.text_byte;
      end
      if (advance && dec_emit) begin
         out_token_ff <= dec_token;
      end
   end

   assign rsp.valid      = out_valid_ff;
   assign rsp.token_kind = out_token_ff.token_kind;
   assign rsp.field_byte = out_token_ff.field_byte;

   // quoting can only be closed after it was opened
   a_close_after_open: assert property (@(posedge clock) disable iff (reset)
      flags_ff.quote_closed |-> flags_ff.quote_opened)
      else $error("quote closed while not opened");

   // any field-ending token clears all flags
   a_end_clears: assert property (@(posedge clock) disable iff (reset)
      (advance && dec_emit && dec_token.token_kind != KIND_BYTE) |=> (flags_ff == '0))
      else $error("flags not cleared after field end");

   // non-byte tokens carry a zero byte
   a_zero_byte: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && out_token_ff.token_kind != KIND_BYTE)
         |-> (out_token_ff.field_byte == CH_END))
      else $error("nonzero byte on end token");

   // a token is never lost: a stalled token stays valid
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (out_valid_ff && !rsp.ready) |=> out_valid_ff)
      else $error("stalled token dropped");

endmodule
